[sv/vitld_pkg.sv]
`timescale 1ns / 1ps

package vitld_pkg;

   localparam int NUM_STATES_DEF      = 8;
   localparam int MAX_STEPS_DEF       = 1024;
   localparam int SCORE_FRAC_BITS_DEF = 16;

   localparam logic [3:0] STATES_IN_USE_RESET = 4'd8;

   localparam logic [2:0] OP_SET_TRANS  = 3'd0;
   localparam logic [2:0] OP_SET_INIT   = 3'd1;
   localparam logic [2:0] OP_EMISSION   = 3'd2;
   localparam logic [2:0] OP_START      = 3'd3;
   localparam logic [2:0] OP_FINISH     = 3'd4;
   localparam logic [2:0] OP_READ_PATH  = 3'd5;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_EMPTY     = 3'd1;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd2;
   localparam logic [2:0] STATUS_ORDER     = 3'd3;
   localparam logic [2:0] STATUS_BAD_INDEX = 3'd4;

   typedef struct packed {
      logic               z;
      logic signed [31:0] v;
   } score_type;

   localparam int SCORE_W = $bits(score_type);

   function automatic score_type score_add(input score_type a, input score_type b);
      logic signed [32:0] s;
      score_type          r;
      s = 33'(a.v) + 33'(b.v);
      r.z = 1'b0;
      if (a.z || b.z) begin
         r.z = 1'b1;
         r.v = 32'sd0;
      end else if (s > 33'sh0_7FFF_FFFF) begin
         r.v = 32'sh7FFF_FFFF;
      end else if (s < -33'sh0_8000_0000) begin
         r.v = 32'sh8000_0000;
      end else begin
         r.v = s[31:0];
      end
      return r;
   endfunction

   function automatic logic score_greater(input score_type a, input score_type b);
      return !a.z && (b.z || (a.v > b.v));
   endfunction

endpackage

[sv/vitld_ram.sv]
`timescale 1ns / 1ps

module vitld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/viterbi_log_domain_decoder.sv]
`timescale 1ns / 1ps
// channel   direction  transfer when            contents
// req_      in         req_tvalid & req_tready  one opcode item
// rsp_      out        rsp_tvalid & rsp_tready  result of finish or read path
// csr_      in         csr_valid & csr_ready    states_in_use
//
// loads and start are handled in the idle state; an emission steps through
// the n states in use, one transition memory read per predecessor (the first
// step reads the initial score instead), then writes the new score back
// finish scans the n scores for the best, then traces back, reading one back
// pointer per pass through TB_RD and TB_WR; read path reads the path memory in RP
// reset is synchronous; score arrays come up as log-zero, memories are not cleared
// req_tready stays low while a result waits on rsp_

module viterbi_log_domain_decoder
   import vitld_pkg::*;
#(
   parameter int NUM_STATES      = NUM_STATES_DEF,
   parameter int MAX_STEPS       = MAX_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // row_state, col_state, time_index, log_value
   input  logic [3:0]  req_tuser,  // opcode, value_is_zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // state_number, best_score, path_length, zero pad
   output logic [3:0]  rsp_tuser,  // status, best_is_zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_wdata
);

   localparam int SW     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int NW     = $clog2(NUM_STATES + 1);
   localparam int CNT_W  = $clog2(MAX_STEPS + 1);
   localparam int TR_D   = NUM_STATES * NUM_STATES;
   localparam int TR_AW  = $clog2(TR_D);
   localparam int IN_AW  = SW;
   localparam int BP_D   = MAX_STEPS * NUM_STATES;
   localparam int BP_AW  = $clog2(BP_D);
   localparam int PS_AW  = $clog2(MAX_STEPS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EM_RD = 3'd1;
   localparam logic [2:0] ST_EM_WR = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_TB_RD = 3'd4;
   localparam logic [2:0] ST_TB_WR = 3'd5;
   localparam logic [2:0] ST_RP    = 3'd6;

   // request fields
   logic [2:0]  req_op;
   logic        req_zero;
   logic [2:0]  req_row;
   logic [2:0]  req_col;
   logic [9:0]  req_tix;
   score_type   req_score;
   logic        req_accept;

   assign req_op    = req_tuser[2:0];
   assign req_zero  = req_tuser[3];
   assign req_row   = req_tdata[2:0];
   assign req_col   = req_tdata[5:3];
   assign req_tix   = req_tdata[15:6];
   assign req_score.z = req_zero;
   assign req_score.v = req_zero ? 32'sd0 : req_tdata[47:16];

   // registers
   logic [2:0]        state_ff, state_in;
   logic [3:0]        siu_ff;
   score_type         prev_ff [NUM_STATES];
   score_type         prev_in [NUM_STATES];
   score_type         cur_ff  [NUM_STATES];
   score_type         cur_in  [NUM_STATES];
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [SW-1:0]     cursor_ff, cursor_in;
   logic              too_long_ff, too_long_in;
   logic              order_ff, order_in;
   logic [CNT_W-1:0]  decoded_ff, decoded_in;
   logic [NW-1:0]     j_ff, j_in;
   logic              first_ff, first_in;
   score_type         e_ff, e_in;
   score_type         best_ff, best_in;
   logic [SW-1:0]     arg_ff, arg_in;
   logic [CNT_W-1:0]  t_ff, t_in;
   logic [SW-1:0]     s_ff, s_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_state_ff, rsp_state_in;
   logic [31:0]       rsp_score_ff, rsp_score_in;
   logic              rsp_zero_ff, rsp_zero_in;
   logic [10:0]       rsp_len_ff, rsp_len_in;

   // memory ports
   logic                 tr_we;
   logic [TR_AW-1:0]     tr_waddr, tr_raddr;
   logic [SCORE_W-1:0]   tr_rdata;
   logic                 in_we;
   logic [IN_AW-1:0]     in_waddr, in_raddr;
   logic [SCORE_W-1:0]   in_rdata;
   logic                 bp_we;
   logic [BP_AW-1:0]     bp_waddr, bp_raddr;
   logic [2:0]           bp_wdata, bp_rdata;
   logic                 ps_we;
   logic [PS_AW-1:0]     ps_waddr, ps_raddr;
   logic [2:0]           ps_wdata, ps_rdata;

   logic [NW-1:0] n_act;
   logic [SW-1:0] jm1;
   score_type     cand;
   score_type     new_score;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (siu_ff < 4'd2) begin
         n_act = NW'(2);
      end else if (32'(siu_ff) > NUM_STATES) begin
         n_act = NW'(NUM_STATES);
      end else begin
         n_act = NW'(siu_ff);
      end
   end

   assign jm1       = SW'(j_ff - NW'(1));
   assign cand      = score_add(prev_ff[jm1], score_type'(tr_rdata));
   assign new_score = score_add(best_ff, e_ff);

   assign tr_we    = req_accept && (req_op == OP_SET_TRANS)
                     && (32'(req_row) < NUM_STATES) && (32'(req_col) < NUM_STATES);
   assign tr_waddr = TR_AW'(32'(req_row) * NUM_STATES + 32'(req_col));
   assign tr_raddr = TR_AW'(32'(j_ff) * NUM_STATES + 32'(cursor_ff));
   assign in_we    = req_accept && (req_op == OP_SET_INIT) && (32'(req_col) < NUM_STATES);
   assign in_waddr = IN_AW'(req_col);
   assign in_raddr = cursor_ff;
   assign bp_we    = (state_ff == ST_EM_WR) && !first_ff;
   assign bp_waddr = BP_AW'(32'(step_ff) * NUM_STATES + 32'(cursor_ff));
   assign bp_wdata = 3'(arg_ff);
   assign bp_raddr = BP_AW'(32'(t_ff) * NUM_STATES + 32'(s_ff));
   assign ps_raddr = PS_AW'(req_tix);

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      cursor_in     = cursor_ff;
      too_long_in   = too_long_ff;
      order_in      = order_ff;
      decoded_in    = decoded_ff;
      j_in          = j_ff;
      first_in      = first_ff;
      e_in          = e_ff;
      best_in       = best_ff;
      arg_in        = arg_ff;
      t_in          = t_ff;
      s_in          = s_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_zero_in   = rsp_zero_ff;
      rsp_len_in    = rsp_len_ff;
      ps_we         = 1'b0;
      ps_waddr      = PS_AW'(t_ff - CNT_W'(1));
      ps_wdata      = bp_rdata;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_EMISSION: begin
                     if ((32'(req_col) != 32'(cursor_ff)) || (32'(req_col) >= 32'(n_act))) begin
                        order_in = 1'b1;
                     end else if ((cursor_ff == '0) && (32'(step_ff) >= MAX_STEPS)) begin
                        too_long_in = 1'b1;
                     end else begin
                        e_in     = req_score;
                        first_in = (step_ff == '0);
                        j_in     = '0;
                        state_in = ST_EM_RD;
                     end
                  end
                  OP_START: begin
                     step_in     = '0;
                     cursor_in   = '0;
                     too_long_in = 1'b0;
                     order_in    = 1'b0;
                  end
                  OP_FINISH: begin
                     if (step_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_state_in  = 4'd0;
                        rsp_score_in  = 32'd0;
                        rsp_zero_in   = 1'b0;
                        rsp_len_in    = 11'd0;
                     end else begin
                        arg_in   = '0;
                        j_in     = NW'(1);
                        state_in = ST_SCAN;
                     end
                  end
                  OP_READ_PATH: begin
                     rsp_len_in   = 11'(decoded_ff);
                     rsp_score_in = 32'd0;
                     rsp_zero_in  = 1'b0;
                     if ((32'(req_tix) >= 32'(decoded_ff)) || (32'(req_tix) >= MAX_STEPS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_BAD_INDEX;
                        rsp_state_in  = 4'd0;
                     end else begin
                        state_in = ST_RP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EM_RD: begin
            j_in = j_ff + NW'(1);
            if (first_ff) begin
               if (j_ff != '0) begin
                  best_in  = score_type'(in_rdata);
                  state_in = ST_EM_WR;
               end
            end else if (j_ff != '0) begin
               if ((jm1 == '0) || score_greater(cand, best_ff)) begin
                  best_in = cand;
                  arg_in  = jm1;
               end
               if (j_ff == n_act) begin
                  state_in = ST_EM_WR;
               end
            end
         end
         ST_EM_WR: begin
            cur_in[cursor_ff] = new_score;
            if (32'(cursor_ff) + 1 >= 32'(n_act)) begin
               for (int k = 0; k < NUM_STATES; k++) begin
                  if (k < 32'(n_act)) begin
                     prev_in[k] = (k == 32'(cursor_ff)) ? new_score : cur_ff[k];
                  end
               end
               step_in   = step_ff + CNT_W'(1);
               cursor_in = '0;
            end else begin
               cursor_in = cursor_ff + SW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (j_ff == n_act) begin
               ps_we    = 1'b1;
               ps_waddr = PS_AW'(step_ff - CNT_W'(1));
               ps_wdata = 3'(arg_ff);
               t_in     = step_ff - CNT_W'(1);
               s_in     = arg_ff;
               rsp_state_in = 4'(32'(arg_ff) + 1);
               rsp_zero_in  = prev_ff[arg_ff].z;
               rsp_score_in = prev_ff[arg_ff].z ? 32'd0 : prev_ff[arg_ff].v;
               rsp_len_in   = 11'(step_ff);
               if (too_long_ff) begin
                  rsp_status_in = STATUS_TOO_LONG;
               end else if (order_ff || (cursor_ff != '0)) begin
                  rsp_status_in = STATUS_ORDER;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
               if (step_ff == CNT_W'(1)) begin
                  decoded_in   = step_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_TB_RD;
               end
            end else begin
               if (score_greater(prev_ff[SW'(j_ff)], prev_ff[arg_ff])) begin
                  arg_in = SW'(j_ff);
               end
               j_in = j_ff + NW'(1);
            end
         end
         ST_TB_RD: begin
            state_in = ST_TB_WR;
         end
         ST_TB_WR: begin
            ps_we = 1'b1;
            s_in  = SW'(bp_rdata);
            t_in  = t_ff - CNT_W'(1);
            if (t_ff == CNT_W'(1)) begin
               decoded_in   = step_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_TB_RD;
            end
         end
         ST_RP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_state_in  = 4'(ps_rdata) + 4'd1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         siu_ff       <= STATES_IN_USE_RESET;
         step_ff      <= '0;
         cursor_ff    <= '0;
         too_long_ff  <= 1'b0;
         order_ff     <= 1'b0;
         decoded_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_STATES; k++) begin
            prev_ff[k] <= '{z: 1'b1, v: 32'sd0};
            cur_ff[k]  <= '{z: 1'b1, v: 32'sd0};
         end
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) begin
            siu_ff <= csr_wdata;
         end
         step_ff      <= step_in;
         cursor_ff    <= cursor_in;
         too_long_ff  <= too_long_in;
         order_ff     <= order_in;
         decoded_ff   <= decoded_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      first_ff      <= first_in;
      e_ff          <= e_in;
      best_ff       <= best_in;
      arg_ff        <= arg_in;
      t_ff          <= t_in;
      s_ff          <= s_in;
      rsp_status_ff <= rsp_status_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_zero_ff   <= rsp_zero_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff, rsp_score_ff, rsp_state_ff};
   assign rsp_tuser  = {rsp_zero_ff, rsp_status_ff};

   vitld_ram #(.WIDTH(SCORE_W), .DEPTH(TR_D)) u_trans (
      .clock (clock),
      .we    (tr_we),
      .waddr (tr_waddr),
      .wdata (req_score),
      .raddr (tr_raddr),
      .rdata (tr_rdata)
   );

   vitld_ram #(.WIDTH(SCORE_W), .DEPTH(NUM_STATES)) u_init (
      .clock (clock),
      .we    (in_we),
      .waddr (in_waddr),
      .wdata (req_score),
      .raddr (in_raddr),
      .rdata (in_rdata)
   );

   vitld_ram #(.WIDTH(3), .DEPTH(BP_D)) u_backptr (
      .clock (clock),
      .we    (bp_we),
      .waddr (bp_waddr),
      .wdata (bp_wdata),
      .raddr (bp_raddr),
      .rdata (bp_rdata)
   );

   vitld_ram #(.WIDTH(3), .DEPTH(MAX_STEPS)) u_path (
      .clock (clock),
      .we    (ps_we),
      .waddr (ps_waddr),
      .wdata (ps_wdata),
      .raddr (ps_raddr),
      .rdata (ps_rdata)
   );

endmodule

[tb/sv/viterbi_log_domain_decoder_tb.sv]
`timescale 1ns / 1ps

module viterbi_log_domain_decoder_tb;
   import vitld_pkg::*;

   typedef struct {
      logic [2:0]         op;
      logic [2:0]         row;
      logic [2:0]         col;
      logic [9:0]         tix;
      logic signed [31:0] val;
      logic               vz;
   } hmm_cmd_type;

   typedef struct {
      logic [2:0]  status;
      logic [3:0]  state_no;
      logic [31:0] score;
      logic        score_zero;
      logic [10:0] plen;
   } decode_res_type;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int NS = NUM_STATES_DEF;
   localparam int MS = MAX_STEPS_DEF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // row_state, col_state, time_index, log_value
   logic [3:0]  req_tuser = '0;  // opcode, value_is_zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // state_number, best_score, path_length, zero pad
   logic [3:0]  rsp_tuser;       // status, best_is_zero
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_wdata = '0;

   viterbi_log_domain_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   hmm_cmd_type    pending_cmds[$];
   decode_res_type expected_results[$];
   int             mismatches = 0;
   bit             idling_on = 1'b0;
   bit             cmd_held = 1'b0;

   // decoder copy
   score_type   m_trans[NS*NS];
   score_type   m_init[NS];
   score_type   m_prev[NS];
   score_type   m_cur[NS];
   logic [2:0]  m_bptr[NS*MS];
   logic [2:0]  m_path[MS];
   int          m_steps = 0;
   int          m_cursor = 0;
   logic [1:0]  m_errs = '0;
   int          m_decoded = 0;
   logic [3:0]  m_states_cfg = STATES_IN_USE_RESET;

   function automatic score_type log_sum(score_type a, score_type b);
      score_type r;
      longint    s;
      r.z = 1'b0;
      r.v = '0;
      if (a.z || b.z) begin
         r.z = 1'b1;
         return r;
      end
      s = longint'(a.v) + longint'(b.v);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      r.v = s[31:0];
      return r;
   endfunction

   function automatic bit beats(score_type a, score_type b);
      return !a.z && (b.z || a.v > b.v);
   endfunction

   function automatic int live_states();
      int n;
      n = m_states_cfg;
      if (n < 2) n = 2;
      if (n > NS) n = NS;
      return n;
   endfunction

   function automatic void decode_cmd(hmm_cmd_type c);
      score_type      e, best, p;
      decode_res_type r;
      int             n, arg, k;
      e.z = c.vz;
      e.v = c.vz ? 32'sd0 : c.val;
      n = live_states();
      r = '{default: '0};
      case (c.op)
         OP_SET_TRANS: m_trans[c.row*NS + c.col] = e;
         OP_SET_INIT: m_init[c.col] = e;
         OP_EMISSION: begin
            if (c.col != m_cursor || c.col >= n) begin
               m_errs[1] = 1'b1;
            end else if (m_cursor == 0 && m_steps >= MS) begin
               m_errs[0] = 1'b1;
            end else begin
               if (m_steps == 0) begin
                  m_cur[c.col] = log_sum(m_init[c.col], e);
               end else begin
                  best = log_sum(m_prev[0], m_trans[c.col]);
                  arg = 0;
                  for (k = 1; k < n; k++) begin
                     p = log_sum(m_prev[k], m_trans[k*NS + c.col]);
                     if (beats(p, best)) begin
                        best = p;
                        arg = k;
                     end
                  end
                  m_cur[c.col] = log_sum(best, e);
                  m_bptr[m_steps*NS + c.col] = arg[2:0];
               end
               if (m_cursor + 1 >= n) begin
                  for (k = 0; k < n; k++) m_prev[k] = m_cur[k];
                  m_steps++;
                  m_cursor = 0;
               end else begin
                  m_cursor++;
               end
            end
         end
         OP_START: begin
            m_steps = 0;
            m_cursor = 0;
            m_errs = '0;
         end
         OP_FINISH: begin
            if (m_steps == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               arg = 0;
               for (k = 1; k < n; k++) if (beats(m_prev[k], m_prev[arg])) arg = k;
               m_path[m_steps-1] = arg[2:0];
               for (k = m_steps - 1; k > 0; k--) m_path[k-1] = m_bptr[k*NS + m_path[k]];
               m_decoded = m_steps;
               if (m_errs[0]) r.status = STATUS_TOO_LONG;
               else if (m_errs[1] || m_cursor != 0) r.status = STATUS_ORDER;
               else r.status = STATUS_OK;
               r.state_no = 4'(arg + 1);
               r.score = m_prev[arg].z ? 32'd0 : m_prev[arg].v;
               r.score_zero = m_prev[arg].z;
               r.plen = 11'(m_decoded);
            end
            expected_results.push_back(r);
         end
         OP_READ_PATH: begin
            if (c.tix >= m_decoded) r.status = STATUS_BAD_INDEX;
            else r.state_no = 4'(m_path[c.tix]) + 4'd1;
            r.plen = 11'(m_decoded);
            expected_results.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      hmm_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            c = pending_cmds.pop_front();
            decode_cmd(c);
            cmd_held = 1'b0;
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds[0];
            cmd_held = 1'b1;
            req_tdata <= {c.val, c.tix, c.col, c.row};
            req_tuser <= {c.vz, c.op};
            req_tvalid <= 1'b1;
            req_gap = idling_on ? $urandom_range(0, 3) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      mismatches++;
   endtask

   // result monitor
   int rsp_stall = 0;
   always @(posedge clock) begin
      decode_res_type w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report("unexpected transfer", rsp_tdata, 0);
            end else begin
               w = expected_results.pop_front();
               if (rsp_tuser[2:0] != w.status) report("status", rsp_tuser[2:0], w.status);
               if (rsp_tdata[3:0] != w.state_no) report("state", rsp_tdata[3:0], w.state_no);
               if (rsp_tdata[35:4] != w.score) report("score", rsp_tdata[35:4], w.score);
               if (rsp_tuser[3] != w.score_zero) report("zero", rsp_tuser[3], w.score_zero);
               if (rsp_tdata[46:36] != w.plen) report("length", rsp_tdata[46:36], w.plen);
               if (rsp_tdata[47] != 1'b0) report("pad", rsp_tdata[47], 0);
            end
            rsp_stall = idling_on ? $urandom_range(0, 3) : 0;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic add_cmd(logic [2:0] op, logic [2:0] row, logic [2:0] col,
                          logic [9:0] tix, logic signed [31:0] val, logic vz);
      hmm_cmd_type c;
      c.op = op;
      c.row = row;
      c.col = col;
      c.tix = tix;
      c.val = val;
      c.vz = vz;
      pending_cmds.push_back(c);
   endtask

   function automatic logic signed [31:0] rand_log();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3: return $urandom;
         default: return -$signed({1'b0, 31'($urandom_range(0, 32'h0040_0000))});
      endcase
   endfunction

   task automatic add_emission(logic [2:0] col);
      add_cmd(OP_EMISSION, 3'($urandom), col, 10'($urandom), rand_log(),
              $urandom_range(0, 9) == 0);
   endtask

   task automatic wait_quiet();
      while (pending_cmds.size() != 0 || cmd_held || expected_results.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_states(logic [3:0] v);
      wait_quiet();
      csr_wdata <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      m_states_cfg = v;
      csr_valid <= 1'b0;
   endtask

   task automatic load_model();
      int r, c;
      for (r = 0; r < NS; r++) begin
         for (c = 0; c < NS; c++)
            add_cmd(OP_SET_TRANS, 3'(r), 3'(c), 10'($urandom), rand_log(),
                    $urandom_range(0, 7) == 0);
         add_cmd(OP_SET_INIT, 3'($urandom), 3'(r), 10'($urandom), rand_log(),
                 $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      logic [3:0] cfg_pick[8];
      int issued, seq_no, n, steps, s, k, drop;
      cfg_pick = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd1, 4'd7};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      add_cmd(OP_FINISH, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      add_cmd(OP_READ_PATH, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      add_cmd(OP_SPARE_A, 3'd7, 3'd7, 10'h3FF, -32'sd1, 1'b1);
      add_cmd(OP_SPARE_B, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      load_model();
      add_cmd(OP_START, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      for (k = 0; k < 2*NS; k++)
         add_cmd(OP_EMISSION, 3'd7, 3'(k % NS), 10'h3FF,
                 (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000, k == 5);
      add_cmd(OP_EMISSION, 3'd0, 3'd4, 10'd0, 32'sd0, 1'b0);
      add_cmd(OP_FINISH, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      add_cmd(OP_READ_PATH, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      add_cmd(OP_READ_PATH, 3'd0, 3'd0, 10'd1, 32'sd0, 1'b0);
      add_cmd(OP_READ_PATH, 3'd7, 3'd7, 10'd2, 32'sd0, 1'b1);
      add_cmd(OP_READ_PATH, 3'd0, 3'd0, 10'h3FF, 32'sd0, 1'b0);

      // sequence running past the step limit
      write_states(4'd2);
      add_cmd(OP_START, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      for (k = 0; k < 2*MS; k++) add_emission(3'(k % 2));
      add_emission(3'd0);
      add_cmd(OP_FINISH, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);
      add_cmd(OP_READ_PATH, 3'd0, 3'd0, 10'h3FF, 32'sd0, 1'b0);
      add_cmd(OP_READ_PATH, 3'd0, 3'd0, 10'd0, 32'sd0, 1'b0);

      // random sequences
      issued = 0;
      seq_no = 0;
      while (issued < 1050) begin
         if (seq_no % 6 == 0) write_states(cfg_pick[(seq_no / 6) % 8]);
         idling_on = $urandom_range(0, 3) != 0;
         n = live_states();
         if ($urandom_range(0, 3) == 0) begin
            for (k = 0; k < 4; k++) begin
               add_cmd(OP_SET_TRANS, 3'($urandom), 3'($urandom), 10'($urandom),
                       rand_log(), $urandom_range(0, 7) == 0);
               add_cmd(OP_SET_INIT, 3'($urandom), 3'($urandom), 10'($urandom),
                       rand_log(), $urandom_range(0, 7) == 0);
            end
            issued += 8;
         end
         add_cmd(OP_START, 3'($urandom), 3'($urandom), 10'($urandom), rand_log(),
                 1'($urandom));
         steps = $urandom_range(0, 10);
         drop = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : 0;
         for (s = 0; s < steps; s++)
            for (k = 0; k < n; k++) begin
               if (s == steps - 1 && k >= n - drop) break;
               if ($urandom_range(0, 40) == 0) begin
                  add_emission(3'($urandom));
                  issued++;
               end
               add_emission(3'(k));
               issued++;
            end
         if ($urandom_range(0, 9) == 0) add_cmd(3'($urandom_range(6, 7)), 3'($urandom),
                                                3'($urandom), 10'($urandom), $urandom, 1'b0);
         add_cmd(OP_FINISH, 3'($urandom), 3'($urandom), 10'($urandom), $urandom, 1'($urandom));
         for (k = $urandom_range(1, 5); k > 0; k--)
            add_cmd(OP_READ_PATH, 3'($urandom), 3'($urandom),
                    ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 11)),
                    $urandom, 1'($urandom));
         issued += 8;
         seq_no++;
         wait (pending_cmds.size() < 40);
      end
      wait_quiet();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
sv/vitld_pkg.sv
sv/vitld_ram.sv
sv/viterbi_log_domain_decoder.sv
tb/sv/viterbi_log_domain_decoder_tb.sv
